### design/gdc_pkg.sv
// Shared types and constants for the identifier duplicate cache.
package gdc_pkg;

    localparam int DEFAULT_CAPACITY = 50;
    localparam int GUID_W           = 128;
    localparam int COUNT_OUT_W      = 6;

    typedef logic [GUID_W-1:0] t_guid;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_MARK   = 2'd3
    } t_opcode;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } t_state;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic load;      // capture compare results for a new request
        logic shift_new; // move every entry one place toward the old end
        logic close;     // close the gap left by the selected hit
        logic use_mark;  // select the marked-identifier hit for the close
    } t_cell_ctl;

endpackage

### design/guid_duplicate_cache_top.sv
// Top level of the identifier duplicate cache: control, cell chain and result register.
//
// Usage:
//   Requests enter on s_axis: s_axis_tuser carries the opcode (add, lookup,
//   remove, mark as search), s_axis_tdata the 128-bit identifier. Every request
//   gives exactly one result on m_axis: was_present, entry_count, evicted.
//   The cache is a chain of CAPACITY cells, newest entry in cell 0.
//   Timing: a request is taken in the accept step (all cells compare in parallel and
//   register their hits) and is then applied in ST_APPLY (the hit ripples down the
//   cell chain, cells shift, the result register loads). A new request is taken
//   only after the one before it has been applied, since the compare-then-shift
//   pass through the chain spans both steps.
//   A result waiting in the output register does not block the next accept;
//   if the receiver stalls, the apply cycle of the next request waits until
//   the output register frees, and s_axis_tready stays low meanwhile.
//   Reset (i_rst_n low, synchronous) empties the cache, forgets the marked
//   identifier and drops any pending result; entry storage is not cleared.
module guid_duplicate_cache_top
    import gdc_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] guid_high, [127:64] guid_low
    input  logic [1:0]   s_axis_tuser,  // [1:0] opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [7:0]   m_axis_tdata   // [0] was_present, [6:1] entry_count, [7] evicted
);

    localparam int CW = $clog2(CAPACITY + 1);

    t_state         r_state, n_state;
    t_opcode        r_op;
    t_guid          r_guid;
    t_guid          r_search;
    logic           r_marked;
    logic [CW-1:0]  r_count, n_count;
    logic           r_out_valid;
    logic           r_was_present;
    logic [CW-1:0]  r_out_count;
    logic           r_evicted;
    logic           n_evicted;

    logic           w_accept;
    logic           w_go;
    logic           w_present;
    logic           w_found;
    t_guid          w_in_guid;
    t_cell_ctl      w_ctl;
    logic [CAPACITY:0]   w_seen;
    logic [CAPACITY-1:0] w_hit;
    t_guid          w_entry [CAPACITY];

    assign w_in_guid = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign w_accept  = s_axis_tvalid && s_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept) n_state = ST_APPLY;
            ST_APPLY: if (w_go)     n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_go          = (r_state == ST_APPLY) && (!r_out_valid || m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the request being worked on
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_opcode'(s_axis_tuser);
            r_guid <= w_in_guid;
        end
    end

    assign w_present = |w_hit;
    assign w_found   = w_seen[CAPACITY];

    // Cell control
    always_comb begin
        w_ctl.load      = w_accept;
        w_ctl.shift_new = w_go && (r_op == OP_ADD) && !w_present;
        w_ctl.close     = w_go && ((r_op == OP_REMOVE) || ((r_op == OP_MARK) && r_marked));
        w_ctl.use_mark  = (r_op == OP_MARK);
    end

    // Cell chain, newest entry first
    assign w_seen[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_guid w_prev;
        t_guid w_next;
        if (g == 0) begin : g_first
            assign w_prev = r_guid;
        end else begin : g_mid
            assign w_prev = w_entry[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_inner
            assign w_next = w_entry[g+1];
        end
        gdc_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_valid  (r_count > CW'(g)),
            .i_guid   (w_in_guid),
            .i_search (r_search),
            .i_prev   (w_prev),
            .i_next   (w_next),
            .i_seen   (w_seen[g]),
            .o_seen   (w_seen[g+1]),
            .o_hit    (w_hit[g]),
            .o_entry  (w_entry[g])
        );
    end

    // Entry count and eviction for the request being applied
    always_comb begin
        n_count   = r_count;
        n_evicted = 1'b0;
        if (w_ctl.shift_new) begin
            if (r_count == CW'(CAPACITY)) begin
                n_evicted = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_ctl.close && w_found) begin
            n_count = r_count - CW'(1);
        end
    end

    // Commit count and marked identifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_marked <= 1'b0;
            r_search <= '0;
        end else if (w_go) begin
            r_count <= n_count;
            if (r_op == OP_MARK) begin
                r_marked <= 1'b1;
                r_search <= r_guid;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_was_present <= w_present;
            r_out_count   <= n_count;
            r_evicted     <= n_evicted;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_evicted, COUNT_OUT_W'(r_out_count), r_was_present};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_evict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_evicted) |-> (r_count == CW'(CAPACITY)))
        else $error("eviction reported while cache not full");

    a_accept_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_APPLY))
        else $error("accepted request not applied next");

    a_lookup_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (r_op == OP_LOOKUP)) |=> $stable(r_count))
        else $error("lookup changed entry count");

endmodule

### design/gdc_cell.sv
// One cache slot: holds an identifier, compares it and shifts with its neighbors.
module gdc_cell
    import gdc_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_guid     i_guid,
    input  t_guid     i_search,
    input  t_guid     i_prev,
    input  t_guid     i_next,
    input  logic      i_seen,
    output logic      o_seen,
    output logic      o_hit,
    output t_guid     o_entry
);

    t_guid r_entry;
    logic  r_hit_new;
    logic  r_hit_mark;

    // Capture both compare results when a request is taken
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_hit_new  <= i_valid && (r_entry == i_guid);
            r_hit_mark <= i_valid && (r_entry == i_search);
        end
    end

    // Pass along whether the selected hit lies at or before this slot
    assign o_seen  = i_seen | (i_ctl.use_mark ? r_hit_mark : r_hit_new);
    assign o_hit   = r_hit_new;
    assign o_entry = r_entry;

    // Shift toward the old end on insert, toward the new end behind a removal
    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_new) begin
            r_entry <= i_prev;
        end else if (i_ctl.close && o_seen) begin
            r_entry <= i_next;
        end
    end

endmodule
